// ===== design/ps2m_pkg.sv =====
// Shared types and constants for the PS/2 mouse packet cursor tracker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ps2m_pkg;

  localparam int DATA_W   = 8;
  localparam int POS_W    = 12;
  localparam int BOUND_W  = 13;
  localparam int OUT_W    = 32;

  localparam logic [7:0] SYNC_MASK   = 8'h08;
  localparam logic [7:0] OVF_MASK    = 8'hC0;
  localparam logic [7:0] X_SIGN_MASK = 8'h10;
  localparam logic [7:0] Y_SIGN_MASK = 8'h20;

  localparam int BTN_LEFT_BIT  = 0;
  localparam int BTN_RIGHT_BIT = 1;

  localparam logic [BOUND_W-1:0] FRAME_MAX     = 13'd4096;
  localparam logic [BOUND_W-1:0] WIDTH_RESET   = 13'd640;
  localparam logic [BOUND_W-1:0] HEIGHT_RESET  = 13'd480;
  localparam logic [POS_W-1:0]   POS_X_RESET   = 12'd320;
  localparam logic [POS_W-1:0]   POS_Y_RESET   = 12'd240;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef struct packed {
    logic             done;
    logic [DATA_W-1:0] header;
    logic [DATA_W-1:0] x_byte;
    logic [DATA_W-1:0] y_byte;
  } pkt_t;

endpackage

`default_nettype wire

// ===== design/ps2m_packet.sv =====
// Three-byte packet assembler with bit-3 resync and overflow filtering.
// Depends on ps2m_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ps2m_packet (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       fire,
  input  wire logic [ps2m_pkg::DATA_W-1:0] data_byte,
  input  wire logic                       from_aux,
  output ps2m_pkg::pkt_t                  pkt
);
  import ps2m_pkg::*;

  localparam logic [1:0] PH_HEAD = 2'd0;
  localparam logic [1:0] PH_X    = 2'd1;
  localparam logic [1:0] PH_Y    = 2'd2;

  logic [1:0]        phase;
  logic [DATA_W-1:0] header;
  logic [DATA_W-1:0] x_byte;

  always_comb begin
    pkt.done   = fire && from_aux && (phase == PH_Y) && ((header & OVF_MASK) == '0);
    pkt.header = header;
    pkt.x_byte = x_byte;
    pkt.y_byte = data_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_HEAD;
      header <= '0;
      x_byte <= '0;
    end else if (fire && from_aux) begin
      case (phase)
        PH_X: begin
          x_byte <= data_byte;
          phase  <= PH_Y;
        end
        PH_Y: begin
          phase <= PH_HEAD;
        end
        default: begin
          if ((data_byte & SYNC_MASK) != '0) begin
            header <= data_byte;
            phase  <= PH_X;
          end else begin
            phase <= PH_HEAD;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/ps2m_cursor.sv =====
// Frame bound registers, cursor position state and the add-and-clamp update.
// Depends on ps2m_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ps2m_cursor (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [ps2m_pkg::BOUND_W-1:0] cfg_data,
  input  wire ps2m_pkg::pkt_t              pkt,
  output logic [ps2m_pkg::POS_W-1:0]       pos_x_next,
  output logic [ps2m_pkg::POS_W-1:0]       pos_y_next
);
  import ps2m_pkg::*;

  logic [BOUND_W-1:0] frame_width;
  logic [BOUND_W-1:0] frame_height;
  logic [POS_W-1:0]   pos_x;
  logic [POS_W-1:0]   pos_y;

  logic signed [8:0]       dx;
  logic signed [8:0]       dy;
  logic signed [POS_W+1:0] nx;
  logic signed [POS_W+1:0] ny;

  function automatic logic [POS_W-1:0] limit_of(input logic [BOUND_W-1:0] b);
    logic [BOUND_W-1:0] tmp;
    tmp = b - 13'd1;
    if (b == '0) return '0;
    else if (b > FRAME_MAX) return {POS_W{1'b1}};
    else return tmp[POS_W-1:0];
  endfunction

  function automatic logic [POS_W-1:0] clamp(input logic signed [POS_W+1:0] v,
                                             input logic [POS_W-1:0] hi);
    if (v[POS_W+1]) return '0;
    else if (v[POS_W:0] > {1'b0, hi}) return hi;
    else return v[POS_W-1:0];
  endfunction

  always_comb begin
    dx = {((pkt.header & X_SIGN_MASK) != '0), pkt.x_byte};
    dy = {((pkt.header & Y_SIGN_MASK) != '0), pkt.y_byte};
    nx = $signed({2'b00, pos_x}) + {{5{dx[8]}}, dx};
    ny = $signed({2'b00, pos_y}) - {{5{dy[8]}}, dy};
    pos_x_next = clamp(nx, limit_of(frame_width));
    pos_y_next = clamp(ny, limit_of(frame_height));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH:  frame_width  <= cfg_data;
        CFG_HEIGHT: frame_height <= cfg_data;
        default:    frame_width  <= frame_width;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= POS_X_RESET;
      pos_y <= POS_Y_RESET;
    end else if (pkt.done) begin
      pos_x <= pos_x_next;
      pos_y <= pos_y_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/ps2_mouse_packet_cursor_tracker.sv =====
// Path: a byte accepted into the input register gives its result (if any) on m_tvalid from the output register.
// Throughput: one byte per cycle; the input register advances whenever the output register
// is empty or being taken, so the only stall is a held result on the master side.
// Reset (rst, synchronous): both stages empty, packet phase at header, frame 640x480,
// cursor at 320,240.
`timescale 1ns / 1ps
`default_nettype none

module ps2_mouse_packet_cursor_tracker (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [7:0]                  s_tdata,   // [7:0] data_byte
  input  wire logic                        s_tuser,   // [0] from_aux
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [ps2m_pkg::OUT_W-1:0]       m_tdata,   // [11:0] cursor_x, [23:12] cursor_y,
                                                      // [24] button_left, [25] button_right
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [ps2m_pkg::BOUND_W-1:0] cfg_data
);
  import ps2m_pkg::*;

  logic              in_valid;
  logic [DATA_W-1:0] in_byte;
  logic              in_aux;
  logic              out_free;
  logic              fire;
  pkt_t              pkt;
  logic [POS_W-1:0]  pos_x_next;
  logic [POS_W-1:0]  pos_y_next;

  assign out_free = !m_tvalid || m_tready;
  assign fire     = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_aux  <= s_tuser;
    end
  end

  ps2m_packet u_packet (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .data_byte (in_byte),
    .from_aux  (in_aux),
    .pkt       (pkt)
  );

  ps2m_cursor u_cursor (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pkt        (pkt),
    .pos_x_next (pos_x_next),
    .pos_y_next (pos_y_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= pkt.done;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt.done) begin
      m_tdata <= {{(OUT_W - 2 * POS_W - 2){1'b0}},
                  pkt.header[BTN_RIGHT_BIT], pkt.header[BTN_LEFT_BIT],
                  pos_y_next, pos_x_next};
    end
  end

endmodule

`default_nettype wire

// ===== design/ps2m_checker.sv =====
// Port-level checks for the cursor tracker, bound to the top level.
// Depends on ps2m_pkg and ps2_mouse_packet_cursor_tracker.
`timescale 1ns / 1ps
`default_nettype none

module ps2m_checker (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  s_tready,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [ps2m_pkg::OUT_W-1:0] m_tdata
);
  import ps2m_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OUT_W-1:2*POS_W+2] == '0)
    else $error("padding bits set in result");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_stall: assert property (@(posedge clk)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without a held result");

endmodule

bind ps2_mouse_packet_cursor_tracker ps2m_checker u_ps2m_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== verif/ps2_mouse_packet_cursor_tracker_tb.sv =====
// Self-checking testbench for ps2_mouse_packet_cursor_tracker: mouse and keyboard bytes
// go in, cursor transactions come out and are checked against an in-bench cursor tracker.
// Depends on design/ps2m_pkg.sv and design/ps2_mouse_packet_cursor_tracker.sv.
`timescale 1ns / 1ps

module ps2_mouse_packet_cursor_tracker_tb;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [7:0] data;
    logic       aux;
  } ps2_byte_t;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic        left;
    logic        right;
  } cursor_t;

  typedef enum logic [1:0] {PH_HEADER, PH_XBYTE, PH_YBYTE} pkt_phase_t;
  typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_LONG_STALL} ready_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [ps2m_pkg::OUT_W-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic cfg_index = ps2m_pkg::CFG_WIDTH;
  logic [ps2m_pkg::BOUND_W-1:0] cfg_data = '0;

  ps2_mouse_packet_cursor_tracker u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // tracker copy
  logic [ps2m_pkg::BOUND_W-1:0] trk_width  = ps2m_pkg::WIDTH_RESET;
  logic [ps2m_pkg::BOUND_W-1:0] trk_height = ps2m_pkg::HEIGHT_RESET;
  pkt_phase_t  trk_phase = PH_HEADER;
  logic [7:0]  trk_header = 8'h00;
  logic [7:0]  trk_xbyte = 8'h00;
  logic [11:0] trk_x = ps2m_pkg::POS_X_RESET;
  logic [11:0] trk_y = ps2m_pkg::POS_Y_RESET;

  ps2_byte_t byte_q[$];
  cursor_t   cursor_q[$];

  int err_count = 0;
  int cursors_checked = 0;
  int bytes_sent = 0;
  int aux_bytes = 0;
  int frames_used = 1;
  int cycle_count = 0;
  logic sent_hit = 1'b0;

  function automatic logic [11:0] bound_limit(input logic [ps2m_pkg::BOUND_W-1:0] b);
    if (b == '0) return 12'd0;
    if (b > ps2m_pkg::FRAME_MAX) return 12'd4095;
    return 12'(b - 1'b1);
  endfunction

  function automatic logic [11:0] clamp_axis(input logic signed [13:0] v, input logic [11:0] lim);
    if (v < 0) return 12'd0;
    if (v > $signed({2'b00, lim})) return lim;
    return v[11:0];
  endfunction

  function automatic void advance_cursor(input logic [7:0] data, input logic aux);
    logic signed [13:0] dx, dy, nx, ny;
    cursor_t c;
    if (!aux) return;
    case (trk_phase)
      PH_XBYTE: begin
        trk_xbyte = data;
        trk_phase = PH_YBYTE;
      end
      PH_YBYTE: begin
        trk_phase = PH_HEADER;
        if ((trk_header & ps2m_pkg::OVF_MASK) == 8'h00) begin
          dx = $signed({{6{trk_header[4]}}, trk_xbyte});
          dy = $signed({{6{trk_header[5]}}, data});
          nx = $signed({2'b00, trk_x}) + dx;
          ny = $signed({2'b00, trk_y}) - dy;
          trk_x = clamp_axis(nx, bound_limit(trk_width));
          trk_y = clamp_axis(ny, bound_limit(trk_height));
          c.x = trk_x;
          c.y = trk_y;
          c.left = trk_header[ps2m_pkg::BTN_LEFT_BIT];
          c.right = trk_header[ps2m_pkg::BTN_RIGHT_BIT];
          cursor_q.push_back(c);
        end
      end
      default: begin
        trk_phase = PH_HEADER;
        if ((data & ps2m_pkg::SYNC_MASK) != 8'h00) begin
          trk_header = data;
          trk_phase = PH_XBYTE;
        end
      end
    endcase
  endfunction

  // monitor and prediction
  always @(posedge clk) begin
    cursor_t want;
    if (rst) begin
      sent_hit <= 1'b0;
    end else begin
      sent_hit <= s_tvalid && s_tready;
      if (cfg_we) begin
        if (cfg_index == ps2m_pkg::CFG_WIDTH) trk_width = cfg_data;
        else trk_height = cfg_data;
      end
      if (m_tvalid && m_tready) begin
        if (cursor_q.size() == 0) begin
          $error("unexpected cursor transaction: %h", m_tdata);
          err_count++;
        end else begin
          want = cursor_q.pop_front();
          cursors_checked++;
          if (m_tdata[11:0] != want.x) begin
            $error("cursor_x: expected %0d, got %0d", want.x, m_tdata[11:0]);
            err_count++;
          end
          if (m_tdata[23:12] != want.y) begin
            $error("cursor_y: expected %0d, got %0d", want.y, m_tdata[23:12]);
            err_count++;
          end
          if (m_tdata[24] != want.left) begin
            $error("button_left: expected %0d, got %0d", want.left, m_tdata[24]);
            err_count++;
          end
          if (m_tdata[25] != want.right) begin
            $error("button_right: expected %0d, got %0d", want.right, m_tdata[25]);
            err_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        bytes_sent++;
        advance_cursor(s_tdata, s_tuser);
      end
    end
  end

  // byte driver: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    ps2_byte_t cur;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || sent_hit) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (byte_q.size() > 0) begin
        cur = byte_q.pop_front();
        s_tdata <= cur.data;
        s_tuser <= cur.aux;
        s_tvalid <= 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // cursor receiver stall pattern
  ready_mode_t ready_mode = RDY_ALWAYS;
  int ready_left = 0;
  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 3));
      ready_left = $urandom_range(16, 96);
    end
    ready_left--;
    case (ready_mode)
      RDY_ALWAYS:  m_tready <= 1'b1;
      RDY_COIN:    m_tready <= 1'($urandom_range(0, 1));
      RDY_SPARSE:  m_tready <= ($urandom_range(0, 3) == 0);
      default:     m_tready <= ((ready_left % 20) < 4);
    endcase
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic aux);
    ps2_byte_t item;
    item.data = b;
    item.aux = aux;
    byte_q.push_back(item);
    if (aux) aux_bytes++;
  endtask

  task automatic push_packet(input logic [7:0] h, input logic [7:0] xb, input logic [7:0] yb);
    push_byte(h, 1'b1);
    push_byte(xb, 1'b1);
    push_byte(yb, 1'b1);
  endtask

  task automatic wait_idle();
    while (byte_q.size() != 0 || s_tvalid || cursor_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_frame(input logic [12:0] w, input logic [12:0] h);
    wait_idle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= ps2m_pkg::CFG_WIDTH;
    cfg_data <= w;
    @(negedge clk);
    cfg_index <= ps2m_pkg::CFG_HEIGHT;
    cfg_data <= h;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    frames_used++;
  endtask

  function automatic logic [7:0] pick_delta();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic random_traffic(input int n_aux);
    int target;
    int r;
    logic [7:0] h;
    target = aux_bytes + n_aux;
    while (aux_bytes < target) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        h = 8'($urandom_range(0, 255)) | ps2m_pkg::SYNC_MASK;
        if ($urandom_range(0, 7) != 0) h = h & ~ps2m_pkg::OVF_MASK;
        push_byte(h, 1'b1);
        if ($urandom_range(0, 9) == 0) push_byte(8'($urandom_range(0, 255)), 1'b0);
        push_byte(pick_delta(), 1'b1);
        if ($urandom_range(0, 9) == 0) push_byte(8'($urandom_range(0, 255)), 1'b0);
        push_byte(pick_delta(), 1'b1);
      end else if (r < 80) begin
        push_byte(8'($urandom_range(0, 255)), 1'b0);
      end else if (r < 90) begin
        push_byte(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        push_byte(8'($urandom_range(0, 255)) | ps2m_pkg::SYNC_MASK, 1'b1);
        push_byte(pick_delta(), 1'b1);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset frame
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(8'hF7, 1'b1);
    push_packet(8'h08, 8'h00, 8'h00);
    push_byte(8'h0B, 1'b1);
    push_byte(8'h5A, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'hFF, 1'b1);
    push_packet(8'h18, 8'h00, 8'h00);
    push_packet(8'h28, 8'h00, 8'h00);
    push_packet(8'hC8, 8'h12, 8'h34);
    push_packet(8'h4F, 8'hFF, 8'hFF);
    push_packet(8'h8A, 8'h01, 8'h01);
    push_packet(8'h3B, 8'h80, 8'h7F);

    set_frame(13'd1, 13'd1);
    push_packet(8'h08, 8'h7F, 8'h80);
    random_traffic(140);
    set_frame(13'd4096, 13'd4096);
    random_traffic(140);
    set_frame(13'd0, 13'd0);
    random_traffic(140);
    set_frame(13'h1FFF, 13'd4097);
    random_traffic(140);
    set_frame(13'd2, 13'd4095);
    random_traffic(140);
    repeat (3) begin
      set_frame(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)));
      random_traffic(140);
    end

    wait_idle();
    repeat (10) @(posedge clk);
    $display("%0d bytes sent (%0d from the mouse port), %0d cursor transactions checked,",
             bytes_sent, aux_bytes, cursors_checked);
    $display("%0d frame settings including zero, one, 4096 and over-range bounds", frames_used);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", err_count);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/ps2m_pkg.sv
design/ps2m_packet.sv
design/ps2m_cursor.sv
design/ps2_mouse_packet_cursor_tracker.sv
design/ps2m_checker.sv
verif/ps2_mouse_packet_cursor_tracker_tb.sv
